FILE: hdl/lts_pkg.sv
// Shared types, constants and helper functions of the lit texel block shader.
// Used by the top level, lts_front and lts_back; depends on nothing else.
package lts_pkg;

  localparam int COLORMAP_ROWS  = 64;
  localparam int MAX_BLOCK_SIDE = 16;
  localparam int CMD_DEPTH      = 4;
  localparam int OUT_DEPTH      = 4;
  localparam int LIGHT_W        = 18;
  localparam int LIGHT_ROW_LSB  = 8;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TEXEL = 2'd2
  } func_e;

  typedef struct packed {
    logic        wr;
    logic [15:0] word;
    logic [7:0]  val;
    logic        row_done;
    logic        block_done;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_done;
    logic       block_done;
  } res_t;

  function automatic int floor_log2(input int v);
    int k;
    k = 0;
    while (k < 8 && (v >> (k + 1)) != 0) begin
      k = k + 1;
    end
    return k;
  endfunction

  function automatic logic [LIGHT_W-1:0] diff_step(input logic [LIGHT_W-1:0] a,
                                                   input logic [LIGHT_W-1:0] b,
                                                   input logic [2:0] s);
    logic signed [LIGHT_W:0] d;
    logic signed [LIGHT_W:0] r;
    d = $signed({a[LIGHT_W-1], a}) - $signed({b[LIGHT_W-1], b});
    r = d >>> s;
    return r[LIGHT_W-1:0];
  endfunction

  function automatic logic [7:0] row_mod(input logic [7:0] v, input int rows);
    logic [15:0] t;
    logic [15:0] m;
    t = {8'd0, v};
    for (int k = 7; k >= 0; k--) begin
      m = 16'(rows << k);
      if (t >= m) begin
        t = t - m;
      end
    end
    return t[7:0];
  endfunction

endpackage

FILE: hdl/lit_texel_block_shader.sv
// Top level of the lit texel block shader: front end, command queue and back end.
// Depends on lts_pkg, lts_front, lts_fifo and lts_back.
//
//   Channel   Handshake                 Payload
//   input     push / full               func, table_index, table_value, four corners, texel
//   result    empty / pop               pixel, row_done, block_done
//   config    cfg_valid_i / cfg_ready_o mip_level
//
// One item is accepted per cycle while the four-entry command queue has room.
// A texel's pixel passes the command queue, the colormap read and the result buffer on its way out.
// The colormap RAM has one port, which table writes and lookups share.
// Reset clears all control state at once; the colormap has no clearing pass.
// A stalled result side fills the result buffer, then the queue, then raises full.
module lit_texel_block_shader #(
  parameter int COLORMAP_ROWS  = lts_pkg::COLORMAP_ROWS,
  parameter int MAX_BLOCK_SIDE = lts_pkg::MAX_BLOCK_SIDE
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func_i,
  input  logic [13:0] table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic [13:0] light_top_left_i,
  input  logic [13:0] light_top_right_i,
  input  logic [13:0] light_bottom_left_i,
  input  logic [13:0] light_bottom_right_i,
  input  logic [7:0]  texel_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  pixel_o,
  output logic        row_done_o,
  output logic        block_done_o
);

  localparam int QCW = $clog2(lts_pkg::CMD_DEPTH + 1);

  logic           cmd_push, cmd_pop, cmd_empty;
  logic [QCW-1:0] cmd_count;
  lts_pkg::cmd_t  cmd_in, cmd_out;
  lts_pkg::res_t  res;

  assign cfg_ready_o = 1'b1;

  lts_front #(
    .COLORMAP_ROWS  (COLORMAP_ROWS),
    .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE)
  ) u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_data_i           (cfg_data_i),
    .push_i               (push),
    .func_i               (func_i),
    .table_index_i        (table_index_i),
    .table_value_i        (table_value_i),
    .light_top_left_i     (light_top_left_i),
    .light_top_right_i    (light_top_right_i),
    .light_bottom_left_i  (light_bottom_left_i),
    .light_bottom_right_i (light_bottom_right_i),
    .texel_i              (texel_i),
    .full_i               (full),
    .cmd_push_o           (cmd_push),
    .cmd_o                (cmd_in)
  );

  lts_fifo #(
    .W     ($bits(lts_pkg::cmd_t)),
    .DEPTH (lts_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (full),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  lts_back #(
    .COLORMAP_ROWS (COLORMAP_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign pixel_o      = res.pixel;
  assign row_done_o   = res.row_done;
  assign block_done_o = res.block_done;

  a_queue_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_count == '0) == cmd_empty)
    else $error("command queue count disagrees with its empty flag");

endmodule

FILE: hdl/lts_ram.sv
// Generic single-port RAM with a registered read.
// Has no dependencies.
module lts_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [W-1:0]             wdata_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lts_fifo.sv
// Small register FIFO with occupancy count, used for the command queue and result buffer.
// Has no dependencies; the depth must be a power of two.
module lts_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [W-1:0]               data_i,
  input  logic                       pop_i,
  output logic [W-1:0]               data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + PW'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + PW'(1) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/lts_front.sv
// Front end: accepts items, keeps the block's light interpolation state and issues commands.
// Depends on lts_pkg.
module lts_front #(
  parameter int COLORMAP_ROWS  = lts_pkg::COLORMAP_ROWS,
  parameter int MAX_BLOCK_SIDE = lts_pkg::MAX_BLOCK_SIDE
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [1:0]    cfg_data_i,
  input  logic          push_i,
  input  logic [1:0]    func_i,
  input  logic [13:0]   table_index_i,
  input  logic [7:0]    table_value_i,
  input  logic [13:0]   light_top_left_i,
  input  logic [13:0]   light_top_right_i,
  input  logic [13:0]   light_bottom_left_i,
  input  logic [13:0]   light_bottom_right_i,
  input  logic [7:0]    texel_i,
  input  logic          full_i,
  output logic          cmd_push_o,
  output lts_pkg::cmd_t cmd_o
);

  localparam int LW       = lts_pkg::LIGHT_W;
  localparam int MaxShift = lts_pkg::floor_log2(MAX_BLOCK_SIDE);
  localparam int Depth    = COLORMAP_ROWS * 256;

  logic [1:0]    mip_q;
  logic [2:0]    shift_q, shift_d, start_shift;
  logic [LW-1:0] left_q, left_d, right_q, right_d;
  logic [LW-1:0] lstep_q, lstep_d, rstep_q, rstep_d;
  logic [LW-1:0] run_q, run_d, rstp_q, rstp_d;
  logic [LW-1:0] left_n, right_n;
  logic [3:0]    col_q, col_d, row_q, row_d, side_last;
  logic [4:0]    side;
  logic          open_q, open_d;
  logic          accept, end_row, end_block;
  logic [LW-1:0] tl, tr, bl, br;

  assign accept      = push_i & ~full_i;
  assign start_shift = (MaxShift > int'(mip_q)) ? 3'(MaxShift - int'(mip_q)) : 3'd0;
  assign side        = (5'd1 << shift_q) - 5'd1;
  assign side_last   = side[3:0];
  assign end_row     = (col_q >= side_last);
  assign end_block   = end_row & (row_q >= side_last);
  assign left_n      = left_q + lstep_q;
  assign right_n     = right_q + rstep_q;
  assign tl          = LW'(light_top_left_i);
  assign tr          = LW'(light_top_right_i);
  assign bl          = LW'(light_bottom_left_i);
  assign br          = LW'(light_bottom_right_i);

  always_comb begin
    shift_d    = shift_q;
    left_d     = left_q;
    right_d    = right_q;
    lstep_d    = lstep_q;
    rstep_d    = rstep_q;
    run_d      = run_q;
    rstp_d     = rstp_q;
    col_d      = col_q;
    row_d      = row_q;
    open_d     = open_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    unique case (lts_pkg::func_e'(func_i))
      lts_pkg::FUNC_LOAD: begin
        cmd_o.wr   = 1'b1;
        cmd_o.word = 16'(table_index_i);
        cmd_o.val  = table_value_i;
        cmd_push_o = accept & (32'(table_index_i) < 32'(Depth));
      end
      lts_pkg::FUNC_START: begin
        if (accept) begin
          shift_d = start_shift;
          left_d  = tl;
          right_d = tr;
          lstep_d = lts_pkg::diff_step(bl, tl, start_shift);
          rstep_d = lts_pkg::diff_step(br, tr, start_shift);
          run_d   = tr;
          rstp_d  = lts_pkg::diff_step(tl, tr, start_shift);
          col_d   = '0;
          row_d   = '0;
          open_d  = 1'b1;
        end
      end
      lts_pkg::FUNC_TEXEL: begin
        cmd_o.word       = run_q[15:0];
        cmd_o.val        = texel_i;
        cmd_o.row_done   = end_row;
        cmd_o.block_done = end_block;
        cmd_push_o       = accept & open_q;
        if (accept && open_q) begin
          run_d = run_q + rstp_q;
          if (end_row) begin
            col_d   = '0;
            left_d  = left_n;
            right_d = right_n;
            run_d   = right_n;
            rstp_d  = lts_pkg::diff_step(left_n, right_n, shift_q);
            if (end_block) begin
              row_d  = '0;
              open_d = 1'b0;
            end else begin
              row_d = row_q + 4'd1;
            end
          end else begin
            col_d = col_q + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mip_q   <= '0;
      shift_q <= '0;
      left_q  <= '0;
      right_q <= '0;
      lstep_q <= '0;
      rstep_q <= '0;
      run_q   <= '0;
      rstp_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      open_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mip_q <= cfg_data_i;
      end
      shift_q <= shift_d;
      left_q  <= left_d;
      right_q <= right_d;
      lstep_q <= lstep_d;
      rstep_q <= rstep_d;
      run_q   <= run_d;
      rstp_q  <= rstp_d;
      col_q   <= col_d;
      row_q   <= row_d;
      open_q  <= open_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !cmd_push_o)
    else $error("command pushed into a full queue");

  a_block_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && !cmd_o.wr && cmd_o.block_done) |=> !open_q)
    else $error("block still open after its final texel");

  a_block_done_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && !cmd_o.wr && cmd_o.block_done) |-> cmd_o.row_done)
    else $error("final texel of a block does not end a row");

endmodule

FILE: hdl/lts_back.sv
// Back end: executes colormap writes and lookups and buffers the results.
// Depends on lts_pkg, lts_ram and lts_fifo.
module lts_back #(
  parameter int COLORMAP_ROWS = lts_pkg::COLORMAP_ROWS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  lts_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lts_pkg::res_t res_o
);

  localparam int Depth = COLORMAP_ROWS * 256;
  localparam int AW    = $clog2(Depth);
  localparam int OD    = lts_pkg::OUT_DEPTH;
  localparam int CW    = $clog2(OD + 1);

  logic          inflight_q;
  logic          rd_row_done_q, rd_block_done_q;
  logic [CW-1:0] out_count;
  logic [CW:0]   used;
  logic          issue_ok, out_full, ram_rd;
  logic [7:0]    row_m;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  lts_pkg::res_t out_res;

  assign used      = (CW + 1)'(out_count) + (CW + 1)'(inflight_q);
  assign issue_ok  = (used < (CW + 1)'(OD));
  assign cmd_pop_o = ~cmd_empty_i & (cmd_i.wr | issue_ok);
  assign ram_rd    = cmd_pop_o & ~cmd_i.wr;
  assign row_m     = lts_pkg::row_mod(cmd_i.word[15:8], COLORMAP_ROWS);
  assign ram_addr  = cmd_i.wr ? AW'(cmd_i.word) : AW'({row_m, cmd_i.val});

  lts_ram #(
    .W     (8),
    .DEPTH (Depth)
  ) u_colormap (
    .clk_i   (clk_i),
    .en_i    (cmd_pop_o),
    .we_i    (cmd_i.wr),
    .addr_i  (ram_addr),
    .wdata_i (cmd_i.val),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 1'b0;
    end else begin
      inflight_q <= ram_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_rd) begin
      rd_row_done_q   <= cmd_i.row_done;
      rd_block_done_q <= cmd_i.block_done;
    end
  end

  always_comb begin
    out_res.pixel      = ram_rdata;
    out_res.row_done   = rd_row_done_q;
    out_res.block_done = rd_block_done_q;
  end

  lts_fifo #(
    .W     ($bits(lts_pkg::res_t)),
    .DEPTH (OD)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (inflight_q),
    .data_i  (out_res),
    .pop_i   (pop_i),
    .data_o  (res_o),
    .full_o  (out_full),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q |-> !out_full)
    else $error("lookup result arrives at a full result buffer");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= (CW + 1)'(OD))
    else $error("outstanding results exceed the result buffer");

endmodule
